// File: rtl/core/lncosh_pkg.sv
// Shared types, constants and angle/log tables for the complex log-cosh accumulator.
package lncosh_pkg;

  // Default configuration
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 20;

  // Datapath widths: Q30 working registers, multiplier operands, exponent/quadrant counter
  localparam int DW     = 48;
  localparam int MW     = 34;
  localparam int PW     = 2 * MW;
  localparam int KW     = 18;
  localparam int IDX_W  = 6;
  localparam int TAB_N  = 33;
  localparam int IN_W   = 24;
  localparam int ACC_W  = 40;

  // Q30 constants
  localparam logic signed [DW-1:0] ONE_Q         = 48'sd1073741824;
  localparam logic signed [DW-1:0] HALF_Q        = 48'sd536870912;
  localparam logic signed [DW-1:0] LN2_Q         = 48'sd744261118;
  localparam logic signed [DW-1:0] LOG2E_Q       = 48'sd1549082005;
  localparam logic signed [DW-1:0] HALFPI_Q      = 48'sd1686629713;
  localparam logic signed [DW-1:0] PI_Q          = 48'sd3373259426;
  localparam logic signed [DW-1:0] QPI_Q         = 48'sd843314857;
  localparam logic signed [DW-1:0] TWO_OVER_PI_Q = 48'sd683565276;
  localparam logic signed [DW-1:0] INV_GAIN_Q    = 48'sd652032874;
  localparam logic signed [DW-1:0] EXP_CUT_Q     = 48'sd23622320128;

  // Accumulator limits
  localparam logic signed [DW-1:0] ACC_MAX = 48'sd549755813887;
  localparam logic signed [DW-1:0] ACC_MIN = -48'sd549755813888;

  // Product rounding offsets
  localparam logic signed [PW-1:0] RND30 = PW'(64'sd1 <<< 29);
  localparam logic signed [PW-1:0] RND45 = PW'(64'sd1 <<< 44);

  typedef logic [31:0] tab_t [0:TAB_N-1];

  typedef enum logic [1:0] {
    SM_ROT,
    SM_VEC,
    SM_EXP,
    SM_LN
  } step_mode_e;

  typedef struct packed {
    step_mode_e        mode;
    logic [IDX_W-1:0]  idx;
  } step_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXP0, ST_EXP1, ST_EXP2, ST_EXP3, ST_EXP4, ST_EXP5, ST_EXP6,
    ST_SC0, ST_SC1, ST_SC2, ST_SC3, ST_SC4,
    ST_CX0, ST_CX1, ST_SY1,
    ST_V0, ST_V1, ST_V2, ST_V3,
    ST_LN1, ST_LN2, ST_LN3, ST_LN4,
    ST_ACC
  } state_e;

  // Alternating series sum of 2^(-i*k)/k in Q62, rounded to Q30 (elaboration only)
  function automatic logic [31:0] series_f(input int unsigned i, input int unsigned step);
    logic signed [63:0] s;
    logic        [63:0] term;
    logic signed [63:0] r;
    int unsigned        k;
    int unsigned        sh;
    logic               neg;
    s   = '0;
    neg = 1'b0;
    for (k = 1; k <= 62; k += step) begin
      sh = i * k;
      if (i != 0 && sh <= 62) begin
        term = (64'd1 << (62 - sh)) / 64'(k);
        if (neg) s = s - $signed(term);
        else     s = s + $signed(term);
        neg = ~neg;
      end
    end
    r = (s + 64'sd2147483648) >>> 32;
    return r[31:0];
  endfunction

  function automatic tab_t ln_tab_f();
    tab_t t;
    for (int i = 0; i < TAB_N; i++) t[i] = series_f(i, 1);
    return t;
  endfunction

  function automatic tab_t atan_tab_f();
    tab_t t;
    for (int i = 0; i < TAB_N; i++) begin
      if (i == 0) t[i] = QPI_Q[31:0];
      else        t[i] = series_f(i, 2);
    end
    return t;
  endfunction

  // ln(1+2^-i) and atan(2^-i) in Q30
  localparam tab_t LN_TAB   = ln_tab_f();
  localparam tab_t ATAN_TAB = atan_tab_f();

endpackage

// File: rtl/core/complex_lncosh_accumulator.sv
// Top level: sequencer, working registers and saturating accumulators for sum of ln(cosh(a+ib)).
//
// Usage:
// - Input channel (in_valid_i/in_ready_o) carries one element a+ib in signed
//   fixed point with FRAC_BITS fraction bits, plus is_last_i.
// - Output channel (out_valid_o/out_ready_i) carries the two 40-bit saturating
//   sums once an element marked last has been folded in; both sums then clear.
// - Each element runs exp, sin/cos, vectoring and ln in turn on one shift-add
//   step unit and one shared multiplier; in_ready_o is high only between
//   elements. An element's run grows with CORDIC_STEPS, with each exp range
//   fixup and with each shift that normalizes the ln operand, most of all for
//   a near-zero magnitude. A large real part skips the exp loop.
// - A result waits in the output register while the next elements are taken;
//   only an element marked last stalls in its final cycle until the previous
//   result has left.
// - Reset (rst_ni low, asynchronous) clears both running sums, the output valid and
//   the sequencer; the block is ready right after reset.
module complex_lncosh_accumulator #(
  parameter int FRAC_BITS    = lncosh_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = lncosh_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [lncosh_pkg::IN_W-1:0]     elem_re_i,
  input  logic signed [lncosh_pkg::IN_W-1:0]     elem_im_i,
  input  logic                                   is_last_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [lncosh_pkg::ACC_W-1:0]    sum_re_o,
  output logic signed [lncosh_pkg::ACC_W-1:0]    sum_im_o
);

  localparam int DW  = lncosh_pkg::DW;
  localparam int MW  = lncosh_pkg::MW;
  localparam int PW  = lncosh_pkg::PW;
  localparam int KW  = lncosh_pkg::KW;
  localparam int IW  = lncosh_pkg::IDX_W;
  localparam int AW  = lncosh_pkg::ACC_W;
  localparam int SH  = 30 - FRAC_BITS;
  localparam logic signed [DW-1:0] TO_RND = DW'(64'sd1 <<< (SH - 1));

  lncosh_pkg::state_e state_q, state_d;

  logic signed [lncosh_pkg::IN_W-1:0] a_q, b_q;
  logic                               last_q;
  logic signed [DW-1:0] x_q, x_d, y_q, y_d, z_q, z_d, t_q, t_d, ang_q, ang_d;
  logic signed [KW-1:0] k_q, k_d;
  logic [IW-1:0]        i_q, i_d;
  logic signed [AW-1:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic signed [AW-1:0] sum_re_q, sum_re_d, sum_im_q, sum_im_d;
  logic                 out_vld_q, out_vld_d, out_set;

  logic signed [MW-1:0] mop_a, mop_b;
  logic signed [PW-1:0] p_q;
  lncosh_pkg::step_ctl_t ctl;
  logic signed [DW-1:0] sx, sy, sz;

  logic signed [DW-1:0] aq_w, absa_w, xe_w, bq_w, rnd_w, e_w, re_out, im_out;
  logic signed [DW-1:0] sum_re_w, sum_im_w;
  logic signed [PW-1:0] n_w, q_w;
  logic [6:0]           shamt;
  logic                 out_free;

  function automatic logic signed [AW-1:0] sat_f(input logic signed [DW-1:0] v);
    logic signed [AW-1:0] r;
    if (v > lncosh_pkg::ACC_MAX)      r = lncosh_pkg::ACC_MAX[AW-1:0];
    else if (v < lncosh_pkg::ACC_MIN) r = lncosh_pkg::ACC_MIN[AW-1:0];
    else                              r = v[AW-1:0];
    return r;
  endfunction

  // Shared units
  lncosh_mul #(.AW(MW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mop_a),
    .b_i   (mop_b),
    .p_o   (p_q)
  );

  lncosh_step u_step (
    .ctl_i (ctl),
    .x_i   (x_q),
    .y_i   (y_q),
    .z_i   (z_q),
    .x_o   (sx),
    .y_o   (sy),
    .z_o   (sz)
  );

  // Operand scaling to Q30
  assign aq_w   = DW'(a_q) <<< SH;
  assign absa_w = (aq_w < 0) ? -aq_w : aq_w;
  assign xe_w   = absa_w <<< 1;
  assign bq_w   = DW'(b_q) <<< SH;
  assign rnd_w  = DW'((p_q + lncosh_pkg::RND30) >>> 30);
  assign n_w    = p_q >>> 45;
  assign q_w    = (p_q + lncosh_pkg::RND45) >>> 45;
  assign e_w    = x_q + rnd_w;
  assign shamt  = {1'b0, k_q[5:0]} + 7'd1;

  // Term rounding and saturating sums
  assign re_out   = (y_q + TO_RND) >>> SH;
  assign im_out   = (ang_q + TO_RND) >>> SH;
  assign sum_re_w = DW'(acc_re_q) + re_out;
  assign sum_im_w = DW'(acc_im_q) + im_out;
  assign out_free = !out_vld_q || out_ready_i;

  assign in_ready_o  = (state_q == lncosh_pkg::ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign sum_re_o    = sum_re_q;
  assign sum_im_o    = sum_im_q;

  // Sequencer: next state, working registers, unit operands
  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    t_d      = t_q;
    ang_d    = ang_q;
    k_d      = k_q;
    i_d      = i_q;
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    sum_re_d = sum_re_q;
    sum_im_d = sum_im_q;
    out_set  = 1'b0;
    mop_a    = '0;
    mop_b    = '0;
    ctl.mode = lncosh_pkg::SM_ROT;
    ctl.idx  = i_q;

    unique case (state_q)
      lncosh_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lncosh_pkg::ST_EXP0;
      end
      // t = exp(-2|a|): range reduction by ln2
      lncosh_pkg::ST_EXP0: begin
        mop_a = MW'(xe_w >>> 15);
        mop_b = MW'(lncosh_pkg::LOG2E_Q);
        if (xe_w >= lncosh_pkg::EXP_CUT_Q) begin
          t_d     = '0;
          state_d = lncosh_pkg::ST_SC0;
        end else begin
          state_d = lncosh_pkg::ST_EXP1;
        end
      end
      lncosh_pkg::ST_EXP1: begin
        k_d     = KW'(n_w);
        mop_a   = MW'(n_w);
        mop_b   = MW'(lncosh_pkg::LN2_Q);
        state_d = lncosh_pkg::ST_EXP2;
      end
      lncosh_pkg::ST_EXP2: begin
        z_d     = xe_w - DW'(p_q);
        state_d = lncosh_pkg::ST_EXP3;
      end
      lncosh_pkg::ST_EXP3: begin
        priority if (z_q < 0) begin
          k_d = k_q - KW'(1);
          z_d = z_q + lncosh_pkg::LN2_Q;
        end else if (z_q >= lncosh_pkg::LN2_Q) begin
          k_d = k_q + KW'(1);
          z_d = z_q - lncosh_pkg::LN2_Q;
        end else begin
          z_d     = lncosh_pkg::LN2_Q - z_q;
          x_d     = lncosh_pkg::ONE_Q;
          i_d     = IW'(1);
          state_d = lncosh_pkg::ST_EXP4;
        end
      end
      lncosh_pkg::ST_EXP4: begin
        ctl.mode = lncosh_pkg::SM_EXP;
        x_d      = sx;
        z_d      = sz;
        i_d      = i_q + IW'(1);
        if (i_q == IW'(CORDIC_STEPS)) state_d = lncosh_pkg::ST_EXP5;
      end
      lncosh_pkg::ST_EXP5: begin
        mop_a   = MW'(x_q);
        mop_b   = MW'(z_q);
        state_d = lncosh_pkg::ST_EXP6;
      end
      lncosh_pkg::ST_EXP6: begin
        t_d     = DW'($unsigned(e_w) >> shamt);
        state_d = lncosh_pkg::ST_SC0;
      end
      // sin/cos: quadrant reduction, then rotation
      lncosh_pkg::ST_SC0: begin
        mop_a   = MW'(bq_w >>> 15);
        mop_b   = MW'(lncosh_pkg::TWO_OVER_PI_Q);
        state_d = lncosh_pkg::ST_SC1;
      end
      lncosh_pkg::ST_SC1: begin
        k_d     = KW'(q_w);
        mop_a   = MW'(q_w);
        mop_b   = MW'(lncosh_pkg::HALFPI_Q);
        state_d = lncosh_pkg::ST_SC2;
      end
      lncosh_pkg::ST_SC2: begin
        z_d     = bq_w - DW'(p_q);
        x_d     = lncosh_pkg::INV_GAIN_Q;
        y_d     = '0;
        i_d     = '0;
        state_d = lncosh_pkg::ST_SC3;
      end
      lncosh_pkg::ST_SC3: begin
        ctl.mode = lncosh_pkg::SM_ROT;
        x_d      = sx;
        y_d      = sy;
        z_d      = sz;
        i_d      = i_q + IW'(1);
        if (i_q == IW'(CORDIC_STEPS - 1)) state_d = lncosh_pkg::ST_SC4;
      end
      lncosh_pkg::ST_SC4: begin
        // x = cos, y = sin after quadrant fold
        unique case (k_q[1:0])
          2'd0: begin x_d = x_q;  y_d = y_q;  end
          2'd1: begin x_d = -y_q; y_d = x_q;  end
          2'd2: begin x_d = -x_q; y_d = -y_q; end
          default: begin x_d = y_q; y_d = -x_q; end
        endcase
        state_d = lncosh_pkg::ST_CX0;
      end
      // scale by (1+t) and (1-t)
      lncosh_pkg::ST_CX0: begin
        mop_a   = MW'(x_q);
        mop_b   = MW'(lncosh_pkg::ONE_Q + t_q);
        state_d = lncosh_pkg::ST_CX1;
      end
      lncosh_pkg::ST_CX1: begin
        x_d     = rnd_w;
        mop_a   = MW'(y_q);
        mop_b   = MW'(lncosh_pkg::ONE_Q - t_q);
        state_d = lncosh_pkg::ST_SY1;
      end
      lncosh_pkg::ST_SY1: begin
        y_d     = a_q[lncosh_pkg::IN_W-1] ? -rnd_w : rnd_w;
        state_d = lncosh_pkg::ST_V0;
      end
      // vectoring: magnitude and angle
      lncosh_pkg::ST_V0: begin
        i_d = '0;
        if (x_q == '0 && y_q == '0) begin
          z_d     = '0;
          state_d = lncosh_pkg::ST_V2;
        end else begin
          state_d = lncosh_pkg::ST_V1;
          if (x_q < 0) begin
            z_d = (y_q >= 0) ? lncosh_pkg::PI_Q : -lncosh_pkg::PI_Q;
            x_d = -x_q;
            y_d = -y_q;
          end else begin
            z_d = '0;
          end
        end
      end
      lncosh_pkg::ST_V1: begin
        ctl.mode = lncosh_pkg::SM_VEC;
        x_d      = sx;
        y_d      = sy;
        z_d      = sz;
        i_d      = i_q + IW'(1);
        if (i_q == IW'(CORDIC_STEPS - 1)) state_d = lncosh_pkg::ST_V2;
      end
      lncosh_pkg::ST_V2: begin
        mop_a   = MW'(x_q);
        mop_b   = MW'(lncosh_pkg::INV_GAIN_Q);
        ang_d   = z_q;
        state_d = lncosh_pkg::ST_V3;
      end
      lncosh_pkg::ST_V3: begin
        x_d     = (rnd_w < 1) ? DW'(1) : rnd_w;
        k_d     = '0;
        state_d = lncosh_pkg::ST_LN1;
      end
      // ln: normalize into [0.5, 1), then digit steps
      lncosh_pkg::ST_LN1: begin
        priority if (x_q >= lncosh_pkg::ONE_Q) begin
          x_d = x_q >>> 1;
          k_d = k_q + KW'(1);
        end else if (x_q < lncosh_pkg::HALF_Q) begin
          x_d = x_q <<< 1;
          k_d = k_q - KW'(1);
        end else begin
          i_d     = IW'(1);
          z_d     = '0;
          state_d = lncosh_pkg::ST_LN2;
        end
      end
      lncosh_pkg::ST_LN2: begin
        ctl.mode = lncosh_pkg::SM_LN;
        x_d      = sx;
        z_d      = sz;
        i_d      = i_q + IW'(1);
        if (i_q == IW'(CORDIC_STEPS)) state_d = lncosh_pkg::ST_LN3;
      end
      lncosh_pkg::ST_LN3: begin
        mop_a   = MW'(k_q);
        mop_b   = MW'(lncosh_pkg::LN2_Q);
        state_d = lncosh_pkg::ST_LN4;
      end
      lncosh_pkg::ST_LN4: begin
        y_d     = absa_w - lncosh_pkg::LN2_Q + z_q + (x_q - lncosh_pkg::ONE_Q) + DW'(p_q);
        state_d = lncosh_pkg::ST_ACC;
      end
      // fold term into sums; a last element waits for a free output register
      lncosh_pkg::ST_ACC: begin
        if (!last_q || out_free) begin
          state_d = lncosh_pkg::ST_IDLE;
          if (last_q) begin
            sum_re_d = sat_f(sum_re_w);
            sum_im_d = sat_f(sum_im_w);
            out_set  = 1'b1;
            acc_re_d = '0;
            acc_im_d = '0;
          end else begin
            acc_re_d = sat_f(sum_re_w);
            acc_im_d = sat_f(sum_im_w);
          end
        end
      end
      default: begin
        state_d = lncosh_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_vld_d = (out_vld_q && !out_ready_i) || out_set;

  // Control state and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lncosh_pkg::ST_IDLE;
      acc_re_q  <= '0;
      acc_im_q  <= '0;
      out_vld_q <= 1'b0;
      i_q       <= '0;
    end else begin
      state_q   <= state_d;
      acc_re_q  <= acc_re_d;
      acc_im_q  <= acc_im_d;
      out_vld_q <= out_vld_d;
      i_q       <= i_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q    <= elem_re_i;
      b_q    <= elem_im_i;
      last_q <= is_last_i;
    end
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    t_q      <= t_d;
    ang_q    <= ang_d;
    k_q      <= k_d;
    sum_re_q <= sum_re_d;
    sum_im_q <= sum_im_d;
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("block ready right after taking a request");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == lncosh_pkg::ST_ACC && last_q))
    else $error("result raised without a last element");

  // counter ends one past the final step of a loop
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    i_q <= IW'(CORDIC_STEPS + 1))
    else $error("step counter past CORDIC_STEPS + 1");
`endif

endmodule

// File: rtl/core/lncosh_mul.sv
// Shared signed multiplier with registered product.
module lncosh_mul #(
  parameter int AW = lncosh_pkg::MW
) (
  input  logic                   clk_i,
  input  logic signed [AW-1:0]   a_i,
  input  logic signed [AW-1:0]   b_i,
  output logic signed [2*AW-1:0] p_o
);

  logic signed [2*AW-1:0] p_q;

  // Product register
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: rtl/core/lncosh_step.sv
// Shared shift-add step unit: circular CORDIC rotate/vector, exp and ln digit steps.
module lncosh_step (
  input  lncosh_pkg::step_ctl_t                 ctl_i,
  input  logic signed [lncosh_pkg::DW-1:0]      x_i,
  input  logic signed [lncosh_pkg::DW-1:0]      y_i,
  input  logic signed [lncosh_pkg::DW-1:0]      z_i,
  output logic signed [lncosh_pkg::DW-1:0]      x_o,
  output logic signed [lncosh_pkg::DW-1:0]      y_o,
  output logic signed [lncosh_pkg::DW-1:0]      z_o
);

  logic signed [lncosh_pkg::DW-1:0] xs, ys, atan_w, ln_w, c_w;

  assign xs     = x_i >>> ctl_i.idx;
  assign ys     = y_i >>> ctl_i.idx;
  assign atan_w = $signed(lncosh_pkg::DW'(lncosh_pkg::ATAN_TAB[ctl_i.idx]));
  assign ln_w   = $signed(lncosh_pkg::DW'(lncosh_pkg::LN_TAB[ctl_i.idx]));
  assign c_w    = x_i + xs;

  always_comb begin
    x_o = x_i;
    y_o = y_i;
    z_o = z_i;
    unique case (ctl_i.mode)
      lncosh_pkg::SM_ROT: begin
        // drive residual angle z toward zero
        if (z_i >= 0) begin
          x_o = x_i - ys;
          y_o = y_i + xs;
          z_o = z_i - atan_w;
        end else begin
          x_o = x_i + ys;
          y_o = y_i - xs;
          z_o = z_i + atan_w;
        end
      end
      lncosh_pkg::SM_VEC: begin
        // drive y toward zero, collect angle
        if (y_i >= 0) begin
          x_o = x_i + ys;
          y_o = y_i - xs;
          z_o = z_i + atan_w;
        end else begin
          x_o = x_i - ys;
          y_o = y_i + xs;
          z_o = z_i - atan_w;
        end
      end
      lncosh_pkg::SM_EXP: begin
        // x = e, z = remaining exponent
        if (z_i >= ln_w) begin
          z_o = z_i - ln_w;
          x_o = c_w;
        end
      end
      lncosh_pkg::SM_LN: begin
        // x = mantissa, z = log accumulator
        if (c_w <= lncosh_pkg::ONE_Q) begin
          x_o = c_w;
          z_o = z_i - ln_w;
        end
      end
      default: begin
        x_o = x_i;
      end
    endcase
  end

endmodule

// File: sim/tb.sv
// Testbench for the complex log-cosh accumulator: directed rows, then random traffic.
module tb;

  localparam int  IN_W        = lncosh_pkg::IN_W;
  localparam int  ACC_W       = lncosh_pkg::ACC_W;
  localparam int  FRAC        = 16;
  localparam int  STEPS       = 20;
  localparam int  N_RANDOM    = 1400;
  localparam int  CALM_TAIL   = 200;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  DRAIN_WAIT  = 150;

  localparam longint Q_ONE   = 64'sd1073741824;
  localparam longint Q_LN2   = 64'sd744261118;
  localparam longint Q_LOG2E = 64'sd1549082005;
  localparam longint Q_HPI   = 64'sd1686629713;
  localparam longint Q_PI    = 64'sd3373259426;
  localparam longint Q_QPI   = 64'sd843314857;
  localparam longint Q_2OPI  = 64'sd683565276;
  localparam longint Q_KINV  = 64'sd652032874;
  localparam longint Q_ECUT  = 64'sd22 <<< 30;
  localparam longint S_MAX   = 64'sd549755813887;
  localparam longint S_MIN   = -64'sd549755813888;

  typedef struct {
    logic signed [IN_W-1:0] re;
    logic signed [IN_W-1:0] im;
    logic                   last;
  } elem_t;

  typedef struct {
    logic [ACC_W-1:0] re;
    logic [ACC_W-1:0] im;
  } sums_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [IN_W-1:0]  elem_re_i;
  logic signed [IN_W-1:0]  elem_im_i;
  logic                    is_last_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [ACC_W-1:0] sum_re_o;
  logic signed [ACC_W-1:0] sum_im_o;

  complex_lncosh_accumulator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .elem_re_i(elem_re_i), .elem_im_i(elem_im_i), .is_last_i(is_last_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .sum_re_o(sum_re_o), .sum_im_o(sum_im_o)
  );

  // Predictor state
  longint ln_steps   [0:32];
  longint atan_steps [0:32];
  longint run_re, run_im;
  sums_t  sum_fifo [$];
  int     err_cnt;
  bit     calm;
  int     cycle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint ash(longint x, int n);
    if (n >= 63) return (x < 0) ? -64'sd1 : 64'sd0;
    return x >>> n;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return ash(a * b + (Q_ONE >>> 1), 30);
  endfunction

  // Alternating series of 2^(-i*k)/k, summed in Q62, rounded to Q30
  function automatic longint alt_series(int i, int stp);
    longint s;
    longint unsigned term;
    int k, sh;
    bit neg;
    s = 0;
    neg = 0;
    if (i == 0) return 0;
    for (k = 1; k <= 62; k += stp) begin
      sh = i * k;
      if (sh > 62) break;
      term = (64'd1 << (62 - sh)) / longint'(k);
      s = neg ? s - longint'(term) : s + longint'(term);
      neg = ~neg;
    end
    return (s + 64'sd2147483648) >>> 32;
  endfunction

  function automatic longint log_q30(longint v);
    longint e, acc, c;
    e = 0;
    acc = 0;
    if (v < 1) v = 1;
    while (v >= Q_ONE) begin v = v >>> 1; e++; end
    while (v < (Q_ONE >>> 1)) begin v = v <<< 1; e--; end
    for (int i = 1; i <= STEPS; i++) begin
      c = v + (v >>> i);
      if (c <= Q_ONE) begin
        v = c;
        acc -= ln_steps[i];
      end
    end
    return acc + (v - Q_ONE) + e * Q_LN2;
  endfunction

  // exp(-x) for x >= 0
  function automatic longint exp_neg_q30(longint x);
    longint n, r, u, e;
    e = Q_ONE;
    if (x >= Q_ECUT) return 0;
    n = ((x >>> 15) * Q_LOG2E) >>> 45;
    r = x - n * Q_LN2;
    while (r < 0) begin n--; r += Q_LN2; end
    while (r >= Q_LN2) begin n++; r -= Q_LN2; end
    u = Q_LN2 - r;
    for (int i = 1; i <= STEPS; i++) begin
      if (u >= ln_steps[i]) begin
        u -= ln_steps[i];
        e += e >>> i;
      end
    end
    e += qmul(e, u);
    return e >>> (n + 1);
  endfunction

  // One complex term; returns both parts rounded to the output format
  task automatic lncosh_term(input longint a, input longint b,
                             output longint t_re, output longint t_im);
    longint aq, bq, absa, t, q, z, x, y, dx, dy, cs, sn, cx, sy, mag, ang, re;
    int qm;
    aq = a <<< (30 - FRAC);
    bq = b <<< (30 - FRAC);
    absa = (aq < 0) ? -aq : aq;
    t = exp_neg_q30(2 * absa);
    // rotation for sin/cos after quadrant folding
    q = ash(ash(bq, 15) * Q_2OPI + (64'sd1 <<< 44), 45);
    z = bq - q * Q_HPI;
    x = Q_KINV;
    y = 0;
    qm = int'(q & 3);
    for (int i = 0; i < STEPS; i++) begin
      dx = ash(y, i);
      dy = ash(x, i);
      if (z >= 0) begin x -= dx; y += dy; z -= atan_steps[i]; end
      else begin x += dx; y -= dy; z += atan_steps[i]; end
    end
    case (qm)
      0: begin cs = x;  sn = y;  end
      1: begin cs = -y; sn = x;  end
      2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    cx = qmul(cs, Q_ONE + t);
    sy = qmul(sn, Q_ONE - t);
    if (a < 0) sy = -sy;
    // vectoring for magnitude and angle
    if (cx == 0 && sy == 0) begin
      mag = 0;
      ang = 0;
    end else begin
      z = 0;
      x = cx;
      y = sy;
      if (x < 0) begin
        z = (y >= 0) ? Q_PI : -Q_PI;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = ash(y, i);
        dy = ash(x, i);
        if (y >= 0) begin x += dx; y -= dy; z += atan_steps[i]; end
        else begin x -= dx; y += dy; z -= atan_steps[i]; end
      end
      mag = qmul(x, Q_KINV);
      ang = z;
    end
    re = absa - Q_LN2 + log_q30(mag);
    t_re = ash(re + (64'sd1 <<< (29 - FRAC)), 30 - FRAC);
    t_im = ash(ang + (64'sd1 <<< (29 - FRAC)), 30 - FRAC);
  endtask

  function automatic longint clamp_add(longint s, longint v);
    longint r;
    r = s + v;
    if (r > S_MAX) return S_MAX;
    if (r < S_MIN) return S_MIN;
    return r;
  endfunction

  // Fold an accepted element into the running sums
  task automatic fold_element(input elem_t e);
    longint tr, ti;
    sums_t  s;
    lncosh_term(longint'(e.re), longint'(e.im), tr, ti);
    run_re = clamp_add(run_re, tr);
    run_im = clamp_add(run_im, ti);
    if (e.last) begin
      s.re = run_re[ACC_W-1:0];
      s.im = run_im[ACC_W-1:0];
      sum_fifo.push_back(s);
      run_re = 0;
      run_im = 0;
    end
  endtask

  // Drive one request and wait for its acceptance
  task automatic send_elem(input elem_t e);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    elem_re_i  = e.re;
    elem_im_i  = e.im;
    is_last_i  = e.last;
    do @(posedge clk_i); while (!in_ready_o);
    fold_element(e);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic elem_t rand_elem();
    elem_t e;
    case ($urandom_range(0, 3))
      0: e.re = IN_W'($urandom);
      1: e.re = IN_W'($signed($urandom_range(0, 8192)) - 4096);
      2: e.re = IN_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: e.re = IN_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
    if ($urandom_range(0, 2) == 0) e.im = IN_W'($urandom);
    else e.im = IN_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    e.last = ($urandom_range(0, 7) == 0);
    return e;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sum_fifo.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d", $time, sum_re_o, sum_im_o);
        err_cnt++;
      end else begin
        if (sum_re_o !== sum_fifo[0].re) begin
          $display("%0t: sum_re expected %0d actual %0d", $time,
                   $signed(sum_fifo[0].re), sum_re_o);
          err_cnt++;
        end
        if (sum_im_o !== sum_fifo[0].im) begin
          $display("%0t: sum_im expected %0d actual %0d", $time,
                   $signed(sum_fifo[0].im), sum_im_o);
          err_cnt++;
        end
        void'(sum_fifo.pop_front());
      end
    end
  end

  // Receiver back-pressure
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    elem_t dir_rows [$];
    elem_t e;
    in_valid_i = 1'b0;
    elem_re_i  = '0;
    elem_im_i  = '0;
    is_last_i  = 1'b0;
    rst_ni     = 1'b0;
    err_cnt    = 0;
    calm       = 1'b0;
    run_re     = 0;
    run_im     = 0;
    for (int i = 0; i <= 32; i++) begin
      ln_steps[i]   = alt_series(i, 1);
      atan_steps[i] = (i == 0) ? Q_QPI : alt_series(i, 2);
    end

    // directed rows: zero, field extremes, exp cutoff, zero magnitude, negative axis
    dir_rows.push_back('{24'sd0, 24'sd0, 1'b1});
    dir_rows.push_back('{24'sh7FFFFF, 24'sd0, 1'b1});
    dir_rows.push_back('{-24'sh800000, 24'sd0, 1'b1});
    dir_rows.push_back('{24'sd0, 24'sh7FFFFF, 1'b1});
    dir_rows.push_back('{24'sd0, -24'sh800000, 1'b1});
    dir_rows.push_back('{24'sh7FFFFF, 24'sh7FFFFF, 1'b0});
    dir_rows.push_back('{-24'sh800000, -24'sh800000, 1'b1});
    dir_rows.push_back('{24'sd720896, 24'sd1000, 1'b1});
    dir_rows.push_back('{24'sd720895, -24'sd1000, 1'b1});
    dir_rows.push_back('{-24'sd720896, 24'sd51472, 1'b1});
    dir_rows.push_back('{24'sd0, 24'sd102944, 1'b1});
    dir_rows.push_back('{24'sd0, -24'sd102944, 1'b1});
    dir_rows.push_back('{24'sd0, 24'sd205887, 1'b1});
    dir_rows.push_back('{24'sd0, -24'sd205887, 1'b1});
    dir_rows.push_back('{24'sd1, 24'sd205887, 1'b1});
    dir_rows.push_back('{-24'sd1, 24'sd205887, 1'b1});
    dir_rows.push_back('{24'sd65536, 24'sd65536, 1'b0});
    dir_rows.push_back('{-24'sd65536, -24'sd65536, 1'b0});
    dir_rows.push_back('{24'sd32768, -24'sd300000, 1'b1});
    dir_rows.push_back('{-24'sd1, -24'sd1, 1'b1});

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_elem(dir_rows[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= N_RANDOM - CALM_TAIL);
      // hold off until the output side has caught up
      if (n == N_RANDOM / 2) begin
        while (sum_fifo.size() != 0) @(negedge clk_i);
      end
      e = rand_elem();
      if (n == N_RANDOM - 1) e.last = 1'b1;
      send_elem(e);
    end

    while (sum_fifo.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/lncosh_pkg.sv
rtl/core/lncosh_mul.sv
rtl/core/lncosh_step.sv
rtl/core/complex_lncosh_accumulator.sv
sim/tb.sv
